/* design/midi_event_router_cc_decoder_assert.svh */
// Assertion macros shared by the RTL files.
// Each file that includes this header must have i_clk and i_rst_n in scope.
`ifndef MIDI_EVENT_ROUTER_CC_DECODER_ASSERT_SVH
`define MIDI_EVENT_ROUTER_CC_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, prop)
`define ASSERT_NEVER(name, cond)
`endif

`endif

/* design/mercd_pkg.sv */
package mercd_pkg;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [6:0] out_first;
        logic [6:0] out_second;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic      off_first;
        t_out_item res;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        DEC_IDLE = 2'd0,
        DEC_MID  = 2'd1,
        DEC_LOW  = 2'd2
    } t_dec_step;

    localparam logic [1:0] KIND_MONO_ON  = 2'd0;
    localparam logic [1:0] KIND_MONO_OFF = 2'd1;
    localparam logic [1:0] KIND_FORWARD  = 2'd2;
    localparam logic [1:0] KIND_PARAM    = 2'd3;

    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CTRL     = 4'hB;

    localparam logic [1:0] TAG_HEAD_CC  = 2'd0;
    localparam logic [1:0] TAG_MID      = 2'd1;
    localparam logic [1:0] TAG_LOW      = 2'd2;
    localparam logic [1:0] TAG_HEAD_ALT = 2'd3;

    localparam logic REG_MONO_MIN = 1'b0;
    localparam logic REG_TUNNEL   = 1'b1;

    localparam logic [3:0] MONO_MIN_RST = 4'd12;
    localparam logic [6:0] TUNNEL_RST   = 7'd55;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

endpackage

/* design/mercd_front.sv */
`include "midi_event_router_cc_decoder_assert.svh"

module mercd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mercd_pkg::t_in_item i_item,
    output logic                o_full,
    input  logic [3:0]          i_mono_min,
    input  logic [6:0]          i_tunnel,
    input  mercd_pkg::t_q_stat  i_q_stat,
    output logic                o_enq,
    output mercd_pkg::t_cmd     o_cmd
);
    import mercd_pkg::*;

    logic       accept;
    logic [3:0] msg_type;
    logic       mono;
    logic       dec_hit;
    logic [1:0] tag;
    logic [4:0] field;

    logic [6:0] r_held;
    logic [6:0] n_held;
    t_dec_step  r_step;
    t_dec_step  n_step;
    logic       r_type_bit;
    logic       n_type_bit;
    logic       r_sub_bit;
    logic       n_sub_bit;
    logic [3:0] r_high;
    logic [3:0] n_high;
    logic [4:0] r_mid;
    logic [4:0] n_mid;

    logic       dec_emit;
    t_out_item  dec_res;

    assign o_full   = i_q_stat.full;
    assign accept   = i_push && !i_q_stat.full;
    assign msg_type = i_item.status_byte[7:4];
    assign mono     = (i_item.status_byte[3:0] >= i_mono_min);
    assign dec_hit  = accept && mono && (msg_type == MSG_CTRL)
                      && (i_item.first_data == i_tunnel);
    assign tag      = i_item.second_data[1:0];
    assign field    = i_item.second_data[6:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_step     <= DEC_IDLE;
            r_type_bit <= 1'b0;
            r_sub_bit  <= 1'b0;
            r_high     <= '0;
            r_mid      <= '0;
        end else begin
            r_held     <= n_held;
            r_step     <= n_step;
            r_type_bit <= n_type_bit;
            r_sub_bit  <= n_sub_bit;
            r_high     <= n_high;
            r_mid      <= n_mid;
        end
    end

    // tunneled message decoder
    always_comb begin
        n_step     = r_step;
        n_type_bit = r_type_bit;
        n_sub_bit  = r_sub_bit;
        n_high     = r_high;
        n_mid      = r_mid;
        dec_emit   = 1'b0;
        dec_res    = '{result_kind: KIND_PARAM,
                       out_first:   {r_high, r_mid[4:2]},
                       out_second:  {r_mid[1:0], field},
                       last_result: 1'b1};
        if (dec_hit) begin
            case (r_step)
                DEC_MID: begin
                    if (tag == TAG_MID) begin
                        n_mid  = field;
                        n_step = DEC_LOW;
                    end else begin
                        n_step = DEC_IDLE;
                    end
                end
                DEC_LOW: begin
                    n_step   = DEC_IDLE;
                    dec_emit = (tag == TAG_LOW) && !r_type_bit && !r_sub_bit;
                end
                default: begin
                    if (tag == TAG_HEAD_CC || tag == TAG_HEAD_ALT) begin
                        n_type_bit = (tag == TAG_HEAD_ALT);
                        n_sub_bit  = i_item.second_data[6];
                        n_high     = i_item.second_data[5:2];
                        n_step     = DEC_MID;
                    end else begin
                        n_step = DEC_IDLE;
                    end
                end
            endcase
        end
    end

    // route by message type and channel
    always_comb begin
        n_held = r_held;
        o_enq  = 1'b0;
        o_cmd  = '{off_first: 1'b0,
                   res: '{result_kind: KIND_FORWARD,
                          out_first:   i_item.first_data,
                          out_second:  i_item.second_data,
                          last_result: 1'b1}};
        if (accept) begin
            case (msg_type)
                MSG_NOTE_ON: begin
                    o_enq = 1'b1;
                    if (mono) begin
                        o_cmd.off_first       = (i_item.first_data != r_held) && (r_held != '0);
                        o_cmd.res.result_kind = KIND_MONO_ON;
                        o_cmd.res.out_second  = '0;
                        n_held                = i_item.first_data;
                    end
                end
                MSG_NOTE_OFF: begin
                    if (mono) begin
                        if (r_held == i_item.first_data) begin
                            o_enq                 = 1'b1;
                            o_cmd.res.result_kind = KIND_MONO_OFF;
                            o_cmd.res.out_first   = '0;
                            o_cmd.res.out_second  = '0;
                            n_held                = '0;
                        end
                    end else begin
                        o_enq = 1'b1;
                    end
                end
                MSG_CTRL: begin
                    if (mono) begin
                        o_enq     = dec_emit;
                        o_cmd.res = dec_res;
                    end else begin
                        o_enq                 = 1'b1;
                        o_cmd.res.result_kind = KIND_PARAM;
                    end
                end
                default: begin
                    o_enq = 1'b0;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_enq_not_full, o_enq |-> !i_q_stat.full)
endmodule

/* design/mercd_cmdq.sv */
`include "midi_event_router_cc_decoder_assert.svh"

module mercd_cmdq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_enq,
    input  mercd_pkg::t_cmd    i_cmd,
    input  logic               i_deq,
    output mercd_pkg::t_cmd    o_cmd,
    output mercd_pkg::t_q_stat o_stat
);
    import mercd_pkg::*;

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wr;
    logic [CMDQ_AW-1:0]   r_rd;
    logic [CMDQ_AW:0]     r_count;
    logic                 do_enq;
    logic                 do_deq;

    assign o_stat.full  = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_enq       = i_enq && !o_stat.full;
    assign do_deq       = i_deq && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_deq) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_enq && !do_deq) begin
                r_count <= r_count + 1'b1;
            end else if (do_deq && !do_enq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_count_range, r_count > (CMDQ_AW+1)'(CMDQ_DEPTH))
    `ASSERT_CLK(a_deq_has_data, i_deq |-> !o_stat.empty)
endmodule

/* design/mercd_back.sv */
`include "midi_event_router_cc_decoder_assert.svh"

module mercd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mercd_pkg::t_cmd      i_cmd,
    input  mercd_pkg::t_q_stat   i_q_stat,
    output logic                 o_deq,
    input  logic                 i_pop,
    output logic                 o_empty,
    output mercd_pkg::t_out_item o_item
);
    import mercd_pkg::*;

    logic      r_valid;
    logic      n_valid;
    logic      r_phase;
    logic      n_phase;
    t_out_item r_out;
    t_out_item n_out;
    logic      load_ok;

    assign o_empty = !r_valid;
    assign o_item  = r_out;
    assign load_ok = !r_valid || i_pop;

    always_comb begin
        n_valid = r_valid && !i_pop;
        n_phase = r_phase;
        n_out   = r_out;
        o_deq   = 1'b0;
        if (load_ok && !i_q_stat.empty) begin
            n_valid = 1'b1;
            if (i_cmd.off_first && !r_phase) begin
                n_out   = '{result_kind: KIND_MONO_OFF, out_first: '0,
                            out_second: '0, last_result: 1'b0};
                n_phase = 1'b1;
            end else begin
                n_out   = i_cmd.res;
                n_phase = 1'b0;
                o_deq   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    `ASSERT_CLK(a_phase_holds_cmd, r_phase |-> !i_q_stat.empty && i_cmd.off_first)
    `ASSERT_CLK(a_early_is_off, r_valid && !r_out.last_result |-> r_out.result_kind == KIND_MONO_OFF)
endmodule

/* design/midi_event_router_cc_decoder.sv */
// channel  | ports                               | transfer when
// ---------+-------------------------------------+-------------------------------
// events   | push, full, i_data                  | push && !full
// results  | pop, empty, o_data                  | pop && !empty
// config   | psel, penable, pwrite, paddr, pwdata| psel && penable && pwrite
//
// An event is classified in the cycle it is accepted; its command goes into a
// four-entry command queue, and the result stage loads its first result from
// the queue head into the registered result ports. It issues one result per
// cycle while results are popped, so an event with one result sustains one per
// cycle and a mono note on that releases a held note gives a note off result
// first. Reset is synchronous; no clearing pass is needed.
module midi_event_router_cc_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  mercd_pkg::t_in_item  i_data,
    output logic                 empty,
    input  logic                 pop,
    output mercd_pkg::t_out_item o_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mercd_pkg::*;

    logic [3:0] r_mono_min;
    logic [6:0] r_tunnel;
    logic       cfg_wr;
    logic       enq;
    logic       deq;
    t_cmd       enq_cmd;
    t_cmd       head_cmd;
    t_q_stat    q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_min <= MONO_MIN_RST;
            r_tunnel   <= TUNNEL_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MONO_MIN) begin
                r_mono_min <= pwdata[3:0];
            end else begin
                r_tunnel <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TUNNEL: prdata = {25'd0, r_tunnel};
            default:    prdata = {28'd0, r_mono_min};
        endcase
    end

    mercd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_data),
        .o_full     (full),
        .i_mono_min (r_mono_min),
        .i_tunnel   (r_tunnel),
        .i_q_stat   (q_stat),
        .o_enq      (enq),
        .o_cmd      (enq_cmd)
    );

    mercd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_cmd   (enq_cmd),
        .i_deq   (deq),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    mercd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_q_stat (q_stat),
        .o_deq    (deq),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_data)
    );
endmodule

/* tb/sv/midi_route_check.sv */
`timescale 1ns / 100ps

module midi_route_check
    import mercd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_item    i_event,
    input  logic        i_pop,
    input  logic        i_empty,
    input  t_out_item   i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic [3:0] mono_min;
    logic [6:0] tunnel_ctrl;
    logic [6:0] held_note;
    t_dec_step  dec_step;
    logic       saved_alt_type;
    logic       saved_sub;
    logic [3:0] saved_high;
    logic [4:0] saved_mid;

    t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        results_due = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = results_due;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count = mismatch_count + 1;
    endtask

    function automatic t_out_item make_result(input logic [1:0] kind,
                                              input logic [6:0] first,
                                              input logic [6:0] second);
        make_result = '{result_kind: kind, out_first: first, out_second: second,
                        last_result: 1'b0};
    endfunction

    task automatic route_event(input t_in_item ev);
        t_out_item  batch[$];
        logic [3:0] msg;
        logic       mono;
        logic [6:0] frag;
        logic [1:0] tag;
        msg  = ev.status_byte[7:4];
        mono = ev.status_byte[3:0] >= mono_min;
        frag = ev.second_data;
        tag  = frag[1:0];
        if (msg == MSG_NOTE_ON) begin
            if (mono) begin
                if (ev.first_data != held_note && held_note != '0) begin
                    batch.push_back(make_result(KIND_MONO_OFF, '0, '0));
                end
                held_note = ev.first_data;
                batch.push_back(make_result(KIND_MONO_ON, ev.first_data, '0));
            end else begin
                batch.push_back(make_result(KIND_FORWARD, ev.first_data, ev.second_data));
            end
        end else if (msg == MSG_NOTE_OFF) begin
            if (mono) begin
                if (held_note == ev.first_data) begin
                    held_note = '0;
                    batch.push_back(make_result(KIND_MONO_OFF, '0, '0));
                end
            end else begin
                batch.push_back(make_result(KIND_FORWARD, ev.first_data, ev.second_data));
            end
        end else if (msg == MSG_CTRL) begin
            if (!mono) begin
                batch.push_back(make_result(KIND_PARAM, ev.first_data, ev.second_data));
            end else if (ev.first_data == tunnel_ctrl) begin
                case (dec_step)
                    DEC_MID: begin
                        if (tag == TAG_MID) begin
                            saved_mid = frag[6:2];
                            dec_step  = DEC_LOW;
                        end else begin
                            dec_step = DEC_IDLE;
                        end
                    end
                    DEC_LOW: begin
                        dec_step = DEC_IDLE;
                        if (tag == TAG_LOW && !saved_alt_type && !saved_sub) begin
                            batch.push_back(make_result(KIND_PARAM,
                                                        {saved_high, saved_mid[4:2]},
                                                        {saved_mid[1:0], frag[6:2]}));
                        end
                    end
                    default: begin
                        if (tag == TAG_HEAD_CC || tag == TAG_HEAD_ALT) begin
                            saved_alt_type = (tag == TAG_HEAD_ALT);
                            saved_sub      = frag[6];
                            saved_high     = frag[5:2];
                            dec_step       = DEC_MID;
                        end else begin
                            dec_step = DEC_IDLE;
                        end
                    end
                endcase
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last_result = 1'b1;
        end
        foreach (batch[k]) begin
            expected_results.push_back(batch[k]);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d first %0d second %0d",
                                      got.result_kind, got.out_first, got.out_second));
        end else begin
            want = expected_results.pop_front();
            if (got.result_kind !== want.result_kind) begin
                report_mismatch($sformatf("result_kind %0d, want %0d",
                                          got.result_kind, want.result_kind));
            end
            if (got.out_first !== want.out_first) begin
                report_mismatch($sformatf("out_first %0d, want %0d",
                                          got.out_first, want.out_first));
            end
            if (got.out_second !== want.out_second) begin
                report_mismatch($sformatf("out_second %0d, want %0d",
                                          got.out_second, want.out_second));
            end
            if (got.last_result !== want.last_result) begin
                report_mismatch($sformatf("last_result %0d, want %0d",
                                          got.last_result, want.last_result));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mono_min       = MONO_MIN_RST;
            tunnel_ctrl    = TUNNEL_RST;
            held_note      = '0;
            dec_step       = DEC_IDLE;
            saved_alt_type = 1'b0;
            saved_sub      = 1'b0;
            saved_high     = '0;
            saved_mid      = '0;
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_result(i_result);
            end
            if (i_push && !i_full) begin
                route_event(i_event);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_TUNNEL) begin
                    tunnel_ctrl = i_pwdata[6:0];
                end else begin
                    mono_min = i_pwdata[3:0];
                end
            end
        end
        results_due <= expected_results.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import mercd_pkg::*;

    localparam logic [3:0] MSG_POLY_PRESSURE = 4'hA;
    localparam logic [3:0] MSG_SYSTEM        = 4'hF;
    localparam int         EVENTS_PER_PHASE  = 210;
    localparam int         NUM_PHASES        = 6;
    localparam int         SETTLE_CYCLES     = 12;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    t_in_item    i_data  = '0;
    logic        full;
    logic        empty;
    logic        pready;
    logic [31:0] prdata;
    t_out_item   o_data;

    int         send_idle_pct = 26;
    int         recv_idle_pct = 49;
    int         fail_count;
    int         pending_results;
    int         events_sent = 0;
    int         phase_start;
    logic [3:0] mono_min_cfg = MONO_MIN_RST;
    logic [6:0] tunnel_cfg   = TUNNEL_RST;
    logic [6:0] last_note    = '0;
    logic [3:0] next_mono;
    logic [6:0] next_tunnel;

    midi_event_router_cc_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    midi_route_check route_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_event      (i_data),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_result     (o_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_in_item make_event(input logic [3:0] msg, input logic [3:0] chan,
                                            input logic [6:0] first,
                                            input logic [6:0] second);
        make_event = '{status_byte: {msg, chan}, first_data: first, second_data: second};
    endfunction

    function automatic logic [3:0] mono_channel();
        mono_channel = 4'($urandom_range(15, mono_min_cfg));
    endfunction

    function automatic logic [3:0] forward_channel();
        if (mono_min_cfg == '0) begin
            forward_channel = 4'($urandom_range(15));
        end else begin
            forward_channel = 4'($urandom_range(mono_min_cfg - 1, 0));
        end
    endfunction

    task automatic send_event(input t_in_item ev);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= ev;
        do @(posedge i_clk); while (full);
        events_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [3:0] mono_min, input logic [6:0] tunnel);
        wait_drained();
        write_register(REG_MONO_MIN, 32'(mono_min));
        write_register(REG_TUNNEL, 32'(tunnel));
        mono_min_cfg = mono_min;
        tunnel_cfg   = tunnel;
    endtask

    task automatic send_fragments();
        logic [1:0] head_tag;
        logic [6:0] frag[3];
        head_tag = ($urandom_range(3) == 0) ? TAG_HEAD_ALT : TAG_HEAD_CC;
        frag[0]  = {($urandom_range(4) == 0), 4'($urandom_range(15)), head_tag};
        frag[1]  = {5'($urandom_range(31)), TAG_MID};
        frag[2]  = {5'($urandom_range(31)), TAG_LOW};
        if ($urandom_range(6) == 0) begin
            frag[$urandom_range(2)][1:0] = 2'($urandom_range(3));
        end
        foreach (frag[k]) begin
            send_event(make_event(MSG_CTRL, mono_channel(), tunnel_cfg, frag[k]));
        end
    endtask

    task automatic send_random_event();
        int         pick;
        logic       note_on;
        logic [6:0] note;
        logic [3:0] fwd_msg;
        pick = $urandom_range(99);
        if (pick < 30) begin
            note_on = 1'($urandom_range(1));
            note    = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                               : 7'($urandom_range(6));
            if (!note_on && $urandom_range(1) == 1) begin
                note = last_note;
            end
            if (note_on) begin
                last_note = note;
            end
            send_event(make_event(note_on ? MSG_NOTE_ON : MSG_NOTE_OFF, mono_channel(),
                                  note, 7'($urandom_range(127))));
        end else if (pick < 60) begin
            send_fragments();
        end else if (pick < 75) begin
            case ($urandom_range(2))
                0:       fwd_msg = MSG_NOTE_ON;
                1:       fwd_msg = MSG_NOTE_OFF;
                default: fwd_msg = MSG_CTRL;
            endcase
            send_event(make_event(fwd_msg, forward_channel(), 7'($urandom_range(127)),
                                  7'($urandom_range(127))));
        end else if (pick < 85) begin
            send_event(make_event(MSG_CTRL, mono_channel(),
                                  ($urandom_range(1) == 1) ? tunnel_cfg
                                                           : 7'($urandom_range(127)),
                                  7'($urandom_range(127))));
        end else begin
            send_event('{status_byte: 8'($urandom_range(255, 128)),
                         first_data: 7'($urandom_range(127)),
                         second_data: 7'($urandom_range(127))});
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_event(make_event(MSG_NOTE_ON, 4'd0, 7'd127, 7'd127));
        send_event(make_event(MSG_NOTE_OFF, 4'd11, 7'd0, 7'd0));
        send_event(make_event(MSG_CTRL, 4'd0, 7'd127, 7'd0));
        send_event(make_event(MSG_POLY_PRESSURE, 4'd12, 7'd60, 7'd60));
        send_event(make_event(MSG_SYSTEM, 4'd15, 7'd127, 7'd127));
        send_event(make_event(MSG_NOTE_OFF, 4'd12, 7'd0, 7'd0));
        send_event(make_event(MSG_NOTE_ON, 4'd12, 7'd60, 7'd100));
        send_event(make_event(MSG_NOTE_ON, 4'd13, 7'd60, 7'd0));
        send_event(make_event(MSG_NOTE_ON, 4'd15, 7'd127, 7'd1));
        send_event(make_event(MSG_NOTE_OFF, 4'd12, 7'd60, 7'd0));
        send_event(make_event(MSG_NOTE_OFF, 4'd14, 7'd127, 7'd64));
        send_event(make_event(MSG_NOTE_ON, 4'd12, 7'd5, 7'd9));
        send_event(make_event(MSG_NOTE_ON, 4'd12, 7'd0, 7'd9));
        send_event(make_event(MSG_NOTE_ON, 4'd12, 7'd9, 7'd9));
        send_event(make_event(MSG_CTRL, 4'd15, 7'd54, 7'd0));
        send_event(make_event(MSG_CTRL, 4'd12, TUNNEL_RST, {1'b0, 4'hF, TAG_HEAD_CC}));
        send_event(make_event(MSG_CTRL, 4'd12, TUNNEL_RST, {5'h1F, TAG_MID}));
        send_event(make_event(MSG_CTRL, 4'd12, TUNNEL_RST, {5'h1F, TAG_LOW}));
        send_event(make_event(MSG_CTRL, 4'd13, TUNNEL_RST, {1'b0, 4'h0, TAG_HEAD_CC}));
        send_event(make_event(MSG_CTRL, 4'd13, TUNNEL_RST, {5'h00, TAG_MID}));
        send_event(make_event(MSG_CTRL, 4'd13, TUNNEL_RST, {5'h00, TAG_LOW}));
        send_event(make_event(MSG_CTRL, 4'd14, TUNNEL_RST, {1'b0, 4'h5, TAG_HEAD_ALT}));
        send_event(make_event(MSG_CTRL, 4'd14, TUNNEL_RST, {5'h0A, TAG_MID}));
        send_event(make_event(MSG_CTRL, 4'd14, TUNNEL_RST, {5'h15, TAG_LOW}));
        send_event(make_event(MSG_CTRL, 4'd15, TUNNEL_RST, {1'b1, 4'hA, TAG_HEAD_CC}));
        send_event(make_event(MSG_CTRL, 4'd15, TUNNEL_RST, {5'h11, TAG_MID}));
        send_event(make_event(MSG_CTRL, 4'd15, TUNNEL_RST, {5'h0E, TAG_LOW}));
        send_event(make_event(MSG_CTRL, 4'd12, TUNNEL_RST, {5'h03, TAG_HEAD_CC}));
        send_event(make_event(MSG_CTRL, 4'd12, TUNNEL_RST, {5'h04, TAG_LOW}));
        send_event(make_event(MSG_CTRL, 4'd12, TUNNEL_RST, {5'h05, TAG_MID}));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 49;
                recv_idle_pct = 26;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0:       begin next_mono = 4'd0;  next_tunnel = 7'd0;   end
                1:       begin next_mono = 4'd15; next_tunnel = 7'd127; end
                2:       begin next_mono = 4'd12; next_tunnel = 7'd55;  end
                3:       begin next_mono = 4'd8;  next_tunnel = 7'($urandom_range(127)); end
                4:       begin
                    next_mono   = 4'($urandom_range(15));
                    next_tunnel = 7'($urandom_range(127));
                end
                default: begin next_mono = 4'd1;  next_tunnel = 7'd127; end
            endcase
            configure(next_mono, next_tunnel);
            phase_start = events_sent;
            while (events_sent - phase_start < EVENTS_PER_PHASE) begin
                send_random_event();
                if ($urandom_range(149) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* midi_event_router_cc_decoder.f */
+incdir+design
design/mercd_pkg.sv
design/mercd_front.sv
design/mercd_cmdq.sv
design/mercd_back.sv
design/midi_event_router_cc_decoder.sv
tb/sv/midi_route_check.sv
tb/sv/testbench.sv
